>>> design/crc32c_pkg.sv
`timescale 1ns / 1ps

package crc32c_pkg;

  localparam int unsigned BytesPerWord = 8;
  localparam int unsigned WordBytes    = 8;
  localparam int unsigned LaneCnt      = (BytesPerWord > WordBytes) ? WordBytes : BytesPerWord;
  localparam int unsigned LaneIdxW     = (LaneCnt > 1) ? $clog2(LaneCnt) : 1;

  localparam logic [31:0] CrcPoly  = 32'h82F6_3B78;
  localparam logic [31:0] CrcInv   = 32'hFFFF_FFFF;
  localparam logic [7:0]  ByteMask = 8'hFF;

  typedef logic [31:0] crc_t;
  typedef logic [3:0]  count_t;
  typedef logic [LaneIdxW-1:0] lane_idx_t;
  typedef logic [LaneCnt-1:0][31:0] lane_terms_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        is_last;
  } result_t;

  function automatic crc_t crc_byte_step(crc_t crc_in, logic [7:0] data);
    crc_t c;
    c = crc_in ^ {24'd0, data & ByteMask};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/crc32c_in_if.sv
`timescale 1ns / 1ps

interface crc32c_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] prior_crc;

  modport source (output valid, output data_word, output byte_count, output first,
                  output last, output prior_crc, input ready);
  modport sink   (input valid, input data_word, input byte_count, input first,
                  input last, input prior_crc, output ready);
endinterface

>>> design/crc32c_out_if.sv
`timescale 1ns / 1ps

interface crc32c_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        is_last;

  modport source (output valid, output crc_value, output is_last, input ready);
  modport sink   (input valid, input crc_value, input is_last, output ready);
endinterface

>>> design/crc32c_lane.sv
`timescale 1ns / 1ps

module crc32c_lane (
  input  crc32c_pkg::lane_idx_t lane_idx_i,
  input  logic [63:0]           data_word_i,
  input  crc32c_pkg::count_t    byte_count_i,
  output crc32c_pkg::crc_t      term_o
);

  logic [4:0]  pos_sum;
  logic [2:0]  src_idx;
  logic        lane_used;
  logic [63:0] shifted;
  logic [7:0]  lane_byte;
  crc32c_pkg::crc_t acc;

  // Valid bytes sit at the top lanes; lower lanes see zero.
  assign pos_sum   = 5'(lane_idx_i) + 5'(byte_count_i);
  assign lane_used = (pos_sum >= 5'(crc32c_pkg::LaneCnt));
  assign src_idx   = 3'(pos_sum - 5'(crc32c_pkg::LaneCnt));
  assign shifted   = data_word_i >> {src_idx, 3'b000};
  assign lane_byte = lane_used ? shifted[7:0] : 8'd0;

  always_comb begin
    acc = crc32c_pkg::crc_byte_step(32'd0, lane_byte);
    for (int k = 0; k < int'(crc32c_pkg::LaneCnt) - 1; k++) begin
      if (k < (int'(crc32c_pkg::LaneCnt) - 1 - int'(lane_idx_i))) begin
        acc = crc32c_pkg::crc_byte_step(acc, 8'd0);
      end
    end
  end

  assign term_o = acc;

endmodule

>>> design/crc32c_merge.sv
`timescale 1ns / 1ps

module crc32c_merge (
  input  crc32c_pkg::crc_t        start_crc_i,
  input  crc32c_pkg::count_t      byte_count_i,
  input  crc32c_pkg::lane_terms_t lane_terms_i,
  output crc32c_pkg::crc_t        crc_o
);

  crc32c_pkg::crc_t advanced;
  crc32c_pkg::crc_t folded;

  // Advance the start value over one zero byte per absorbed byte.
  always_comb begin
    advanced = start_crc_i;
    for (int k = 0; k < int'(crc32c_pkg::LaneCnt); k++) begin
      if (4'(k) < byte_count_i) begin
        advanced = crc32c_pkg::crc_byte_step(advanced, 8'd0);
      end
    end
  end

  always_comb begin
    folded = '0;
    for (int l = 0; l < int'(crc32c_pkg::LaneCnt); l++) begin
      folded = folded ^ lane_terms_i[l];
    end
  end

  assign crc_o = advanced ^ folded;

endmodule

>>> design/crc32c_multibyte_engine.sv
`timescale 1ns / 1ps

// CRC-32C (reflected, polynomial 0x82F63B78) over a byte stream.
// Input channel in_i: each transfer carries up to eight bytes in data_word,
// byte 0 in bits 7:0 absorbed first; byte_count gives the valid low bytes
// (0 absorbs nothing, counts above eight act as eight). A transfer with first
// set starts from prior_crc (0 for a fresh message, or an earlier result to
// append to); otherwise it continues from the running CRC.
// Output channel out_o: exactly one result per input transfer, in order,
// with the finished CRC of all bytes so far and last echoed as is_last.
// Throughput: one input word per cycle while in_i.ready is high; all eight
// byte lanes and the merge XOR network are combinational, and the running
// CRC register closes the loop word to word. A result is valid on out_o the
// cycle after its transfer, unless out_o stalls and it goes to the skid entry.
// Backpressure: an output register plus one skid entry hold results; while
// out_o stalls, one more input is taken, then in_i.ready drops until the
// receiver resumes.
// Reset: the running CRC becomes all ones (same as prior_crc 0) and both
// result entries empty.

module crc32c_multibyte_engine (
  input logic          clk_i,
  input logic          rst_ni,
  crc32c_in_if.sink    in_i,
  crc32c_out_if.source out_o
);

  crc32c_pkg::count_t      count_sat;
  crc32c_pkg::crc_t        start_crc;
  crc32c_pkg::crc_t        crc_next;
  crc32c_pkg::lane_terms_t lane_terms;
  crc32c_pkg::result_t     new_res;

  crc32c_pkg::crc_t    crc_q, crc_d;
  crc32c_pkg::result_t main_q, main_d;
  crc32c_pkg::result_t skid_q, skid_d;
  logic                main_vld_q, main_vld_d;
  logic                skid_vld_q, skid_vld_d;

  logic push;
  logic pop;

  assign count_sat = (in_i.byte_count > 4'(crc32c_pkg::LaneCnt)) ?
                     4'(crc32c_pkg::LaneCnt) : in_i.byte_count;
  assign start_crc = in_i.first ? (in_i.prior_crc ^ crc32c_pkg::CrcInv) : crc_q;

  for (genvar g = 0; g < int'(crc32c_pkg::LaneCnt); g++) begin : g_lane
    crc32c_lane u_lane (
      .lane_idx_i   (crc32c_pkg::LaneIdxW'(g)),
      .data_word_i  (in_i.data_word),
      .byte_count_i (count_sat),
      .term_o       (lane_terms[g])
    );
  end

  crc32c_merge u_merge (
    .start_crc_i  (start_crc),
    .byte_count_i (count_sat),
    .lane_terms_i (lane_terms),
    .crc_o        (crc_next)
  );

  assign new_res.crc_value = crc_next ^ crc32c_pkg::CrcInv;
  assign new_res.is_last   = in_i.last;

  assign in_i.ready      = !skid_vld_q;
  assign push            = in_i.valid && in_i.ready;
  assign pop             = main_vld_q && out_o.ready;
  assign out_o.valid     = main_vld_q;
  assign out_o.crc_value = main_q.crc_value;
  assign out_o.is_last   = main_q.is_last;

  always_comb begin
    crc_d      = push ? crc_next : crc_q;
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (main_vld_q) begin
      if (pop && push) begin
        main_d = new_res;
      end else if (pop) begin
        main_vld_d = 1'b0;
      end else if (push) begin
        skid_d     = new_res;
        skid_vld_d = 1'b1;
      end
    end else if (push) begin
      main_d     = new_res;
      main_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= crc32c_pkg::CrcInv;
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry held without output entry");

  a_crc_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (crc_q == $past(crc_next)))
    else $error("running CRC not updated on input transfer");

  a_empty_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !in_i.first && (in_i.byte_count == 4'd0)) |=> (crc_q == $past(crc_q)))
    else $error("running CRC changed on empty word");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !main_vld_q) |=>
      (main_vld_q && (main_q.crc_value == ($past(crc_next) ^ crc32c_pkg::CrcInv))))
    else $error("result not presented after transfer into empty output");

endmodule
